// ===== rtl/btw3d_pkg.sv =====
// package of shared types, codes and constants of the block tile walker
`timescale 1ns / 1ps

package btw3d_pkg;

	// default extent width in bits (offsets), counts carry one bit more
	localparam int EXTENT_BITS_DEF = 12;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK = 2'd3;

	// request stream width (request bit in bit 0)
	localparam int IN_TDATA_W = 8;

	// reset value of max_block
	localparam longint MAX_BLOCK_RST = 64'd1048576;

	// tiling mode
	typedef enum logic [1:0] {
		MODE_PLANES = 2'd0,
		MODE_ROWS   = 2'd1,
		MODE_ELEMS  = 2'd2
	} tile_mode_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_ARM,
		ST_EMIT
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic mul_en;
		logic div_start;
		logic div_sel;
		logic latch_quo;
		logic arm;
		logic emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic armed;
		logic div_busy;
		logic out_full;
	} sts_t;

endpackage

// ===== rtl/btw3d_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module btw3d_div #(
	parameter int N = 37,
	parameter int D = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quotient,
	output logic [D-1:0] remainder
);

	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [D:0]    shifted;
	logic          fits;

	// trial subtraction of one step
	assign shifted = {rem_q, quo_q[N-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	// control counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= cnt_q != CW'(1);
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], fits};
			rem_q <= fits ? D'(shifted - {1'b0, dsr_q}) : shifted[D-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/btw3d_dp.sv =====
// datapath: registers, tiling set-up, cursor advance and output register
`timescale 1ns / 1ps

module btw3d_dp import btw3d_pkg::*; #(
	parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [3*EXTENT_BITS:0]     cfg_wdata,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [EXTENT_BITS-1:0]     off_z,
	output logic [EXTENT_BITS-1:0]     off_y,
	output logic [EXTENT_BITS-1:0]     off_x,
	output logic [EXTENT_BITS:0]       cnt_z,
	output logic [EXTENT_BITS:0]       cnt_y,
	output logic [EXTENT_BITS:0]       cnt_x,
	output logic                       final_block
);

	localparam int EB = EXTENT_BITS;
	localparam int EW = EB + 1;
	localparam int AW = EB + 3;
	localparam int LW = 3 * EB + 1;
	localparam int PW = 2 * EB + 1;
	localparam logic [EW-1:0] EXT_MAX = EW'(1) << EB;

	// clamp an extent register into 1 .. 2^EB
	function automatic logic [EW-1:0] eff_ext(input logic [EW-1:0] v);
		if (v == '0)
			return EW'(1);
		else if (v > EXT_MAX)
			return EXT_MAX;
		else
			return v;
	endfunction

	logic [EW-1:0] ext_z_q, ext_y_q, ext_x_q;
	logic [LW-1:0] max_block_q;
	logic [PW-1:0] plane_q;
	logic [EW-1:0] zq_q;
	logic [EW-1:0] row_quota_q, elem_quota_q;
	tile_mode_t    mode_q;
	logic          armed_q;
	logic [EB-1:0] oz_q, oy_q, ox_q;
	logic [EW-1:0] cz_q, cy_q, cx_q;
	logic          out_valid_q;
	logic [EB-1:0] out_oz_q, out_oy_q, out_ox_q;
	logic [EW-1:0] out_cz_q, out_cy_q, out_cx_q;
	logic          out_last_q;

	logic [EW-1:0]   nz, ny, nx;
	logic [LW-1:0]   limit;
	logic [2*EW-1:0] prod;
	logic [LW-1:0]   div_dividend;
	logic [PW-1:0]   div_divisor;
	logic            div_busy;
	logic [LW-1:0]   div_quo;
	logic [PW-1:0]   div_rem;

	logic [AW-1:0] sum_z, sum_y, sum_x, sum2_z, sum2_y, sum2_x;
	logic [EW-1:0] inc_z, inc_y;
	logic          last;
	logic [EB-1:0] n_oz, n_oy, n_ox;
	logic [EW-1:0] n_cz, n_cy, n_cx;

	// effective extents and block limit
	assign nz    = eff_ext(ext_z_q);
	assign ny    = eff_ext(ext_y_q);
	assign nx    = eff_ext(ext_x_q);
	assign limit = (max_block_q == '0) ? LW'(1) : max_block_q;
	assign prod  = nx * ny;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_z_q     <= EW'(1);
			ext_y_q     <= EW'(1);
			ext_x_q     <= EW'(1);
			max_block_q <= LW'(MAX_BLOCK_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXTENT_Z:  ext_z_q     <= cfg_wdata[EW-1:0];
				REG_EXTENT_Y:  ext_y_q     <= cfg_wdata[EW-1:0];
				REG_EXTENT_X:  ext_x_q     <= cfg_wdata[EW-1:0];
				REG_MAX_BLOCK: max_block_q <= cfg_wdata;
			endcase
		end
	end

	// shared divider: limit / plane first, then remainder / row length
	assign div_dividend = cmd.div_sel ? {{(LW-PW){1'b0}}, div_rem} : limit;
	assign div_divisor  = cmd.div_sel ? {{(PW-EW){1'b0}}, nx} : plane_q;

	btw3d_div #(
		.N(LW),
		.D(PW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// set-up intermediates
	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			plane_q <= prod[PW-1:0];
		if (cmd.latch_quo)
			zq_q <= (div_quo > {{(LW-EW){1'b0}}, nz}) ? nz : div_quo[EW-1:0];
	end

	// advance sums
	assign sum_z  = AW'(oz_q) + AW'(cz_q);
	assign sum_y  = AW'(oy_q) + AW'(cy_q);
	assign sum_x  = AW'(ox_q) + AW'(cx_q);
	assign sum2_z = sum_z + AW'(cz_q);
	assign sum2_y = sum_y + AW'(cy_q);
	assign sum2_x = sum_x + AW'(cx_q);
	assign inc_z  = {1'b0, oz_q} + EW'(1);
	assign inc_y  = {1'b0, oy_q} + EW'(1);

	// next block and end of pass
	always_comb begin
		last = 1'b0;
		n_oz = oz_q;
		n_oy = oy_q;
		n_ox = ox_q;
		n_cz = cz_q;
		n_cy = cy_q;
		n_cx = cx_q;
		case (mode_q)
			MODE_PLANES: begin
				if (sum_z >= AW'(nz)) begin
					last = 1'b1;
				end else begin
					n_oz = sum_z[EB-1:0];
					if (sum2_z > AW'(nz))
						n_cz = nz - sum_z[EW-1:0];
				end
			end
			MODE_ROWS: begin
				if (sum_y >= AW'(ny)) begin
					if (inc_z >= nz) begin
						last = 1'b1;
					end else begin
						n_oz = inc_z[EB-1:0];
						n_oy = '0;
						n_cy = row_quota_q;
					end
				end else begin
					n_oy = sum_y[EB-1:0];
					if (sum2_y > AW'(ny))
						n_cy = ny - sum_y[EW-1:0];
				end
			end
			MODE_ELEMS: begin
				if (sum_x >= AW'(nx)) begin
					if (inc_y >= ny) begin
						if (inc_z >= nz) begin
							last = 1'b1;
						end else begin
							n_oz = inc_z[EB-1:0];
							n_oy = '0;
						end
					end else begin
						n_oy = inc_y[EB-1:0];
					end
					n_ox = '0;
					n_cx = elem_quota_q;
				end else begin
					n_ox = sum_x[EB-1:0];
					if (sum2_x > AW'(nx))
						n_cx = nx - sum_x[EW-1:0];
				end
			end
			default: begin
				last = 1'b0;
			end
		endcase
	end

	// tiling state and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			mode_q       <= MODE_PLANES;
			row_quota_q  <= '0;
			elem_quota_q <= '0;
			oz_q         <= '0;
			oy_q         <= '0;
			ox_q         <= '0;
			cz_q         <= '0;
			cy_q         <= '0;
			cx_q         <= '0;
		end else if (cmd.arm) begin
			armed_q      <= 1'b1;
			row_quota_q  <= div_quo[EW-1:0];
			elem_quota_q <= div_rem[EW-1:0];
			oz_q         <= '0;
			oy_q         <= '0;
			ox_q         <= '0;
			if (zq_q != '0) begin
				mode_q <= MODE_PLANES;
				cz_q   <= zq_q;
				cy_q   <= ny;
				cx_q   <= nx;
			end else if (div_quo[EW-1:0] != '0) begin
				mode_q <= MODE_ROWS;
				cz_q   <= EW'(1);
				cy_q   <= div_quo[EW-1:0];
				cx_q   <= nx;
			end else begin
				mode_q <= MODE_ELEMS;
				cz_q   <= EW'(1);
				cy_q   <= EW'(1);
				cx_q   <= div_rem[EW-1:0];
			end
		end else if (cmd.emit) begin
			if (last) begin
				armed_q <= 1'b0;
			end else begin
				oz_q <= n_oz;
				oy_q <= n_oy;
				ox_q <= n_ox;
				cz_q <= n_cz;
				cy_q <= n_cy;
				cx_q <= n_cx;
			end
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_oz_q   <= oz_q;
			out_oy_q   <= oy_q;
			out_ox_q   <= ox_q;
			out_cz_q   <= cz_q;
			out_cy_q   <= cy_q;
			out_cx_q   <= cx_q;
			out_last_q <= last;
		end
	end

	assign sts.armed    = armed_q;
	assign sts.div_busy = div_busy;
	assign sts.out_full = out_valid_q && !m_tready;

	assign m_tvalid    = out_valid_q;
	assign off_z       = out_oz_q;
	assign off_y       = out_oy_q;
	assign off_x       = out_ox_q;
	assign cnt_z       = out_cz_q;
	assign cnt_y       = out_cy_q;
	assign cnt_x       = out_cx_q;
	assign final_block = out_last_q;

endmodule

// ===== rtl/btw3d_ctrl.sv =====
// controller state machine: request handshake and set-up sequencing
`timescale 1ns / 1ps

module btw3d_ctrl import btw3d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic request,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && request)
					state_d = sts.armed ? ST_EMIT : ST_MUL;
			end
			ST_MUL:       state_d = ST_DIV1_GO;
			ST_DIV1_GO:   state_d = ST_DIV1_WAIT;
			ST_DIV1_WAIT: begin
				if (!sts.div_busy)
					state_d = ST_DIV2_GO;
			end
			ST_DIV2_GO:   state_d = ST_DIV2_WAIT;
			ST_DIV2_WAIT: begin
				if (!sts.div_busy)
					state_d = ST_ARM;
			end
			ST_ARM:       state_d = ST_EMIT;
			ST_EMIT: begin
				if (!sts.out_full)
					state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE:      s_tready = 1'b1;
			ST_MUL:       cmd.mul_en = 1'b1;
			ST_DIV1_GO:   cmd.div_start = 1'b1;
			ST_DIV1_WAIT: cmd.div_sel = 1'b0;
			ST_DIV2_GO: begin
				cmd.div_sel   = 1'b1;
				cmd.div_start = 1'b1;
				cmd.latch_quo = 1'b1;
			end
			ST_DIV2_WAIT: cmd.div_sel = 1'b1;
			ST_ARM:       cmd.arm = 1'b1;
			ST_EMIT:      cmd.emit = !sts.out_full;
		endcase
	end

endmodule

// ===== rtl/block_tile_walker_3d.sv =====
// top level of the 3d block tile walker (descriptor generator)
// a request on an armed walker moves to ST_EMIT, which loads its descriptor into the
// output register while the output is not stalled; the next request waits for idle
// first request of a pass runs the tiling set-up, with the shared bit-serial
// divider run twice
// reset: asynchronous, active low; registers to their reset values, walker not armed
`timescale 1ns / 1ps

module block_tile_walker_3d import btw3d_pkg::*; #(
	parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [3*EXTENT_BITS:0]     cfg_wdata,
	// request stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IN_TDATA_W-1:0]      s_tdata,   // request
	// descriptor stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [((6*EXTENT_BITS+3+7)/8)*8-1:0] m_tdata,
	// m_tdata: off_z, off_y, off_x, cnt_z, cnt_y, cnt_x, zero fill
	output logic                       m_tlast    // final_block
);

	localparam int OUT_W       = 6 * EXTENT_BITS + 3;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	cmd_t cmd;
	sts_t sts;

	logic [EXTENT_BITS-1:0] off_z, off_y, off_x;
	logic [EXTENT_BITS:0]   cnt_z, cnt_y, cnt_x;

	// controller
	btw3d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.request  (s_tdata[0]),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	btw3d_dp #(
		.EXTENT_BITS(EXTENT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.sts         (sts),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.off_z       (off_z),
		.off_y       (off_y),
		.off_x       (off_x),
		.cnt_z       (cnt_z),
		.cnt_y       (cnt_y),
		.cnt_x       (cnt_x),
		.final_block (m_tlast)
	);

	// descriptor packing, lowest field first
	assign m_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, cnt_x, cnt_y, cnt_z, off_x, off_y, off_z};

endmodule

// ===== rtl/btw3d_checker.sv =====
// port-level checker of the block tile walker and its bind
`timescale 1ns / 1ps

module btw3d_checker import btw3d_pkg::*; #(
	parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [IN_TDATA_W-1:0]      s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [((6*EXTENT_BITS+3+7)/8)*8-1:0] m_tdata,
	input logic                       m_tlast
);

	localparam int EB = EXTENT_BITS;
	localparam int CZ = 3 * EB;
	localparam int CY = 4 * EB + 1;
	localparam int CX = 5 * EB + 2;

	// stalled descriptor holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("descriptor changed while stalled");

	// a request transfer always takes the walker out of idle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[0] |=> !s_tready)
		else $error("walker still idle after a request");

	// a new descriptor is only loaded while requests are held off
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("descriptor appeared while idle");

	// every descriptor covers at least one element
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CZ+EB:CZ] != '0) && (m_tdata[CY+EB:CY] != '0)
			&& (m_tdata[CX+EB:CX] != '0))
		else $error("descriptor with a zero count");

endmodule

bind block_tile_walker_3d btw3d_checker #(
	.EXTENT_BITS(EXTENT_BITS)
) u_btw3d_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
